// ----- hdl/rbds_pkg.sv -----
// ----------------------------------------------------------------------------
// rbds_pkg
// Shared types, constants and lookup functions for the RAW10 downsampler.
// ----------------------------------------------------------------------------
package rbds_pkg;

  localparam int unsigned MaxRowBytes = 2048;

  localparam logic [10:0] RowBytesReset = 11'd1600;
  localparam int unsigned MinRowBytes   = 5;
  localparam int unsigned CfgDataW      = 11;
  localparam int unsigned CfgIdxW       = 1;

  localparam logic [CfgIdxW-1:0] CfgRowBytes = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgGamma    = 1'b1;

  localparam logic [2:0] GroupLastPos = 3'd4;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  // per-beat tag travelling from the counter stage to the colour stage
  typedef struct packed {
    logic emit;      // fifth byte of an odd-row group
    logic end_row;   // this group closes the output row
  } grp_tag_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_pair;
    logic       end_of_row;
  } pix_t;

  typedef struct packed {
    logic                  space;   // room for one more pixel pair
    logic [FifoCntW-1:0]   count;
  } fifo_stat_t;

  // 10-bit sample from its high byte and the shared low-bits byte
  function automatic logic [9:0] pix10(input logic [7:0] hi, input logic [7:0] lb,
                                       input logic [1:0] pos);
    logic [1:0] lo;
    begin
      case (pos)
        2'd0:    lo = lb[7:6];
        2'd1:    lo = lb[5:4];
        2'd2:    lo = lb[3:2];
        default: lo = lb[1:0];
      endcase
      pix10 = {hi, lo};
    end
  endfunction

  function automatic logic [7:0] clip8(input logic [9:0] v);
    begin
      clip8 = (v > 10'd255) ? 8'hff : v[7:0];
    end
  endfunction

  function automatic logic [7:0] gamma_lut(input logic [6:0] i);
    logic [7:0] v;
    begin
      case (i)
        7'd0: v = 8'd0;     7'd1: v = 8'd28;    7'd2: v = 8'd39;    7'd3: v = 8'd46;
        7'd4: v = 8'd53;    7'd5: v = 8'd59;    7'd6: v = 8'd64;    7'd7: v = 8'd68;
        7'd8: v = 8'd73;    7'd9: v = 8'd77;    7'd10: v = 8'd80;   7'd11: v = 8'd84;
        7'd12: v = 8'd87;   7'd13: v = 8'd90;   7'd14: v = 8'd94;   7'd15: v = 8'd97;
        7'd16: v = 8'd99;   7'd17: v = 8'd102;  7'd18: v = 8'd105;  7'd19: v = 8'd108;
        7'd20: v = 8'd110;  7'd21: v = 8'd113;  7'd22: v = 8'd115;  7'd23: v = 8'd117;
        7'd24: v = 8'd120;  7'd25: v = 8'd122;  7'd26: v = 8'd124;  7'd27: v = 8'd126;
        7'd28: v = 8'd128;  7'd29: v = 8'd130;  7'd30: v = 8'd132;  7'd31: v = 8'd134;
        7'd32: v = 8'd136;  7'd33: v = 8'd138;  7'd34: v = 8'd140;  7'd35: v = 8'd142;
        7'd36: v = 8'd144;  7'd37: v = 8'd146;  7'd38: v = 8'd147;  7'd39: v = 8'd149;
        7'd40: v = 8'd151;  7'd41: v = 8'd153;  7'd42: v = 8'd154;  7'd43: v = 8'd156;
        7'd44: v = 8'd158;  7'd45: v = 8'd159;  7'd46: v = 8'd161;  7'd47: v = 8'd162;
        7'd48: v = 8'd164;  7'd49: v = 8'd165;  7'd50: v = 8'd167;  7'd51: v = 8'd168;
        7'd52: v = 8'd170;  7'd53: v = 8'd171;  7'd54: v = 8'd173;  7'd55: v = 8'd174;
        7'd56: v = 8'd176;  7'd57: v = 8'd177;  7'd58: v = 8'd179;  7'd59: v = 8'd180;
        7'd60: v = 8'd181;  7'd61: v = 8'd183;  7'd62: v = 8'd184;  7'd63: v = 8'd185;
        7'd64: v = 8'd187;  7'd65: v = 8'd188;  7'd66: v = 8'd189;  7'd67: v = 8'd191;
        7'd68: v = 8'd192;  7'd69: v = 8'd193;  7'd70: v = 8'd195;  7'd71: v = 8'd196;
        7'd72: v = 8'd197;  7'd73: v = 8'd198;  7'd74: v = 8'd199;  7'd75: v = 8'd201;
        7'd76: v = 8'd202;  7'd77: v = 8'd203;  7'd78: v = 8'd204;  7'd79: v = 8'd206;
        7'd80: v = 8'd207;  7'd81: v = 8'd208;  7'd82: v = 8'd209;  7'd83: v = 8'd210;
        7'd84: v = 8'd211;  7'd85: v = 8'd212;  7'd86: v = 8'd214;  7'd87: v = 8'd215;
        7'd88: v = 8'd216;  7'd89: v = 8'd217;  7'd90: v = 8'd218;  7'd91: v = 8'd219;
        7'd92: v = 8'd220;  7'd93: v = 8'd221;  7'd94: v = 8'd222;  7'd95: v = 8'd223;
        7'd96: v = 8'd225;  7'd97: v = 8'd226;  7'd98: v = 8'd227;  7'd99: v = 8'd228;
        7'd100: v = 8'd229; 7'd101: v = 8'd230; 7'd102: v = 8'd231; 7'd103: v = 8'd232;
        7'd104: v = 8'd233; 7'd105: v = 8'd234; 7'd106: v = 8'd235; 7'd107: v = 8'd236;
        7'd108: v = 8'd237; 7'd109: v = 8'd238; 7'd110: v = 8'd239; 7'd111: v = 8'd240;
        7'd112: v = 8'd241; 7'd113: v = 8'd242; 7'd114: v = 8'd243; 7'd115: v = 8'd244;
        7'd116: v = 8'd245; 7'd117: v = 8'd246; 7'd118: v = 8'd247; 7'd119: v = 8'd248;
        7'd120: v = 8'd249; 7'd121: v = 8'd249; 7'd122: v = 8'd250; 7'd123: v = 8'd251;
        7'd124: v = 8'd252; 7'd125: v = 8'd253; 7'd126: v = 8'd254;
        default: v = 8'd255;
      endcase
      gamma_lut = v;
    end
  endfunction

endpackage

// ----- hdl/raw10_bayer_downsample_rgb.sv -----
// ----------------------------------------------------------------------------
// raw10_bayer_downsample_rgb
// Packed RAW10 BGGR stream to 2x2 downsampled RGB pixels.
// ----------------------------------------------------------------------------
// Input channel: one packed byte per beat (raw_byte_i, frame_start_i) under
// in_valid_i/in_ready_o. frame_start_i marks the first byte of a frame and
// restarts the row and group position on that byte.
// Output channel: one RGB pixel per beat under out_valid_o/out_ready_i. Each
// five-byte group of an odd row yields two pixels; end_of_row_o flags the
// second pixel of the last whole group of a row.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 row_bytes, 1 gamma_enable); write only while the block is idle.
// Throughput: one byte per cycle, sustained while the receiver takes a pixel
// at least twice per five bytes. The line store is a single RAM written on
// even rows and read on odd rows, one access per byte.
// Path: a group's fifth byte is held in the input stage register; when that
// stage advances the pixel pair is written into the output queue, whose head
// drives the outputs, and the second pixel follows the first.
// Reset: counters and the output queue clear at once; the line store is not
// cleared and an even row must be seen before odd-row pixels mean anything.
// Stall: a four-entry output queue absorbs pixel pairs; when it cannot take a
// pair the input stage holds and in_ready_o drops.
// ----------------------------------------------------------------------------
module raw10_bayer_downsample_rgb #(
  parameter int unsigned MaxRowBytes = rbds_pkg::MaxRowBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    raw_byte_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o,
  output logic                          last_of_pair_o,
  output logic                          end_of_row_o,
  input  logic                          cfg_we_i,
  input  logic [rbds_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rbds_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(MaxRowBytes);

  logic [10:0]          row_bytes_q;
  logic                 gamma_q;
  logic                 b_valid, b_adv;
  logic [7:0]           b_byte;
  rbds_pkg::grp_tag_t   b_tag;
  logic                 mem_we, mem_re;
  logic [AddrW-1:0]     mem_addr;
  logic [7:0]           r0_byte;
  rbds_pkg::pix_t       pix0, pix1, head;
  rbds_pkg::fifo_stat_t fstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= rbds_pkg::RowBytesReset;
      gamma_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbds_pkg::CfgRowBytes: row_bytes_q <= cfg_wdata_i[10:0];
        rbds_pkg::CfgGamma:    gamma_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // a group's fifth byte waits until the queue has room for the pair
  assign b_adv = b_valid && (!b_tag.emit || fstat.space);

  rbds_front #(.MaxRowBytes(MaxRowBytes)) u_front (
    .clk_i, .rst_ni,
    .row_bytes_i   (row_bytes_q),
    .in_valid_i, .in_ready_o, .raw_byte_i, .frame_start_i,
    .b_adv_i       (b_adv),
    .b_valid_o     (b_valid),
    .b_byte_o      (b_byte),
    .b_tag_o       (b_tag),
    .mem_we_o      (mem_we),
    .mem_re_o      (mem_re),
    .mem_addr_o    (mem_addr)
  );

  rbds_ram #(.Width(8), .Depth(MaxRowBytes)) u_line_store (
    .clk_i,
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (raw_byte_i),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (r0_byte)
  );

  rbds_colour u_colour (
    .clk_i,
    .b_adv_i   (b_adv),
    .b_byte_i  (b_byte),
    .b_tag_i   (b_tag),
    .r0_byte_i (r0_byte),
    .gamma_i   (gamma_q),
    .pix0_o    (pix0),
    .pix1_o    (pix1)
  );

  rbds_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i      (b_adv && b_tag.emit),
    .pix0_i      (pix0),
    .pix1_i      (pix1),
    .out_valid_o,
    .out_ready_i,
    .head_o      (head),
    .stat_o      (fstat)
  );

  assign red_o          = head.red;
  assign green_o        = head.green;
  assign blue_o         = head.blue;
  assign last_of_pair_o = head.last_of_pair;
  assign end_of_row_o   = head.end_of_row;

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.count <= rbds_pkg::FifoCntW'(rbds_pkg::FifoDepth))
    else $error("output queue overfilled");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_of_pair_o) |=> (out_valid_o && last_of_pair_o))
    else $error("second pixel of pair missing");

  a_eor_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_row_o) |-> last_of_pair_o)
    else $error("end of row on first pixel of pair");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !b_valid |-> in_ready_o)
    else $error("input stalled with empty stage");

endmodule

// ----- hdl/rbds_ram.sv -----
// ----------------------------------------------------------------------------
// rbds_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rbds_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/rbds_front.sv -----
// ----------------------------------------------------------------------------
// rbds_front
// Row and group counters, line store access and the input stage register.
// ----------------------------------------------------------------------------
module rbds_front #(
  parameter int unsigned MaxRowBytes = rbds_pkg::MaxRowBytes
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [10:0]                      row_bytes_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       raw_byte_i,
  input  logic                             frame_start_i,
  input  logic                             b_adv_i,
  output logic                             b_valid_o,
  output logic [7:0]                       b_byte_o,
  output rbds_pkg::grp_tag_t               b_tag_o,
  output logic                             mem_we_o,
  output logic                             mem_re_o,
  output logic [$clog2(MaxRowBytes)-1:0]   mem_addr_o
);

  localparam int unsigned CntW = $clog2(MaxRowBytes);
  localparam int unsigned CmpW = (CntW + 1 > 11) ? CntW + 1 : 11;

  logic [CntW-1:0] bir_q, bir_d, bir;
  logic [2:0]      big_q, big_d, big;
  logic            odd_q, odd_d, odd;
  logic            accept;
  logic [CmpW-1:0] rb, len, pos;
  logic            row_end;

  logic               b_valid_q;
  logic [7:0]         b_byte_q;
  rbds_pkg::grp_tag_t b_tag_q;

  assign in_ready_o = !b_valid_q || b_adv_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    rb  = CmpW'(row_bytes_i);
    len = rb;
    if (rb < CmpW'(rbds_pkg::MinRowBytes)) begin
      len = CmpW'(rbds_pkg::MinRowBytes);
    end else if (rb > CmpW'(MaxRowBytes)) begin
      len = CmpW'(MaxRowBytes);
    end
  end

  // frame start wipes position before the beat is taken
  assign bir = frame_start_i ? '0 : bir_q;
  assign big = frame_start_i ? '0 : big_q;
  assign odd = frame_start_i ? 1'b0 : odd_q;
  assign pos = CmpW'(bir);
  assign row_end = (pos + CmpW'(1)) >= len;

  always_comb begin
    bir_d = bir_q;
    big_d = big_q;
    odd_d = odd_q;
    if (accept) begin
      if (row_end) begin
        bir_d = '0;
        big_d = '0;
        odd_d = !odd;
      end else begin
        bir_d = bir + CntW'(1);
        big_d = (big >= rbds_pkg::GroupLastPos) ? 3'd0 : big + 3'd1;
        odd_d = odd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bir_q     <= '0;
      big_q     <= '0;
      odd_q     <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      bir_q <= bir_d;
      big_q <= big_d;
      odd_q <= odd_d;
      if (accept) begin
        b_valid_q <= 1'b1;
      end else if (b_adv_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_byte_q        <= raw_byte_i;
      b_tag_q.emit    <= odd && (big == rbds_pkg::GroupLastPos);
      b_tag_q.end_row <= (pos + CmpW'(5)) >= len;
    end
  end

  // even rows fill the store, odd rows read the matching column back
  assign mem_we_o   = accept && !odd;
  assign mem_re_o   = accept && odd;
  assign mem_addr_o = bir;

  assign b_valid_o = b_valid_q;
  assign b_byte_o  = b_byte_q;
  assign b_tag_o   = b_tag_q;

endmodule

// ----- hdl/rbds_colour.sv -----
// ----------------------------------------------------------------------------
// rbds_colour
// Collects a group of both rows and forms the two RGB pixels of the group.
// ----------------------------------------------------------------------------
module rbds_colour (
  input  logic               clk_i,
  input  logic               b_adv_i,
  input  logic [7:0]         b_byte_i,
  input  rbds_pkg::grp_tag_t b_tag_i,
  input  logic [7:0]         r0_byte_i,
  input  logic               gamma_i,
  output rbds_pkg::pix_t     pix0_o,
  output rbds_pkg::pix_t     pix1_o
);

  logic [31:0] r0_sh_q, r1_sh_q;
  logic [7:0]  r0 [5];
  logic [7:0]  r1 [5];
  rbds_pkg::pix_t pix [2];

  // oldest byte sits at the top
  always_ff @(posedge clk_i) begin
    if (b_adv_i && !b_tag_i.emit) begin
      r0_sh_q <= {r0_sh_q[23:0], r0_byte_i};
      r1_sh_q <= {r1_sh_q[23:0], b_byte_i};
    end
  end

  always_comb begin
    r0[0] = r0_sh_q[31:24]; r0[1] = r0_sh_q[23:16];
    r0[2] = r0_sh_q[15:8];  r0[3] = r0_sh_q[7:0];
    r0[4] = r0_byte_i;
    r1[0] = r1_sh_q[31:24]; r1[1] = r1_sh_q[23:16];
    r1[2] = r1_sh_q[15:8];  r1[3] = r1_sh_q[7:0];
    r1[4] = b_byte_i;
  end

  always_comb begin
    logic [10:0] gsum;
    logic [8:0]  hsum;
    for (int k = 0; k < 2; k++) begin
      gsum = {1'b0, rbds_pkg::pix10(r0[2*k+1], r0[4], 2'(2*k+1))}
           + {1'b0, rbds_pkg::pix10(r1[2*k], r1[4], 2'(2*k))};
      hsum = {1'b0, r0[2*k+1]} + {1'b0, r1[2*k]};
      if (gamma_i) begin
        pix[k].red   = rbds_pkg::gamma_lut(r1[2*k+1][7:1]);
        pix[k].green = rbds_pkg::gamma_lut(hsum[8:2]);
        pix[k].blue  = rbds_pkg::gamma_lut(r0[2*k][7:1]);
      end else begin
        pix[k].red   = rbds_pkg::clip8(rbds_pkg::pix10(r1[2*k+1], r1[4], 2'(2*k+1)));
        pix[k].green = rbds_pkg::clip8(gsum[10:1]);
        pix[k].blue  = rbds_pkg::clip8(rbds_pkg::pix10(r0[2*k], r0[4], 2'(2*k)));
      end
      pix[k].last_of_pair = (k == 1);
      pix[k].end_of_row   = (k == 1) && b_tag_i.end_row;
    end
  end

  assign pix0_o = pix[0];
  assign pix1_o = pix[1];

endmodule

// ----- hdl/rbds_fifo.sv -----
// ----------------------------------------------------------------------------
// rbds_fifo
// Output queue: takes a pixel pair in one beat, hands out one pixel a beat.
// ----------------------------------------------------------------------------
module rbds_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rbds_pkg::pix_t       pix0_i,
  input  rbds_pkg::pix_t       pix1_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rbds_pkg::pix_t       head_o,
  output rbds_pkg::fifo_stat_t stat_o
);

  localparam int unsigned PtrW = rbds_pkg::FifoPtrW;
  localparam int unsigned CntW = rbds_pkg::FifoCntW;

  rbds_pkg::pix_t  mem_q [rbds_pkg::FifoDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_pop;
  logic            pop;

  assign pop     = out_valid_o && out_ready_i;
  assign cnt_pop = cnt_q - CntW'(pop);
  assign cnt_d   = cnt_pop + (push_i ? CntW'(2) : CntW'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= wptr_q + PtrW'(2);
      end
      if (pop) begin
        rptr_q <= rptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q]            <= pix0_i;
      mem_q[wptr_q + PtrW'(1)] <= pix1_i;
    end
  end

  assign out_valid_o  = (cnt_q != '0);
  assign head_o       = mem_q[rptr_q];
  assign stat_o.space = cnt_pop <= CntW'(rbds_pkg::FifoDepth - 2);
  assign stat_o.count = cnt_q;

endmodule

// ----- verif/rbds_checker.sv -----
// ----------------------------------------------------------------------------
// rbds_checker
// Watches both channels and the register port of the RAW10 downsampler. Each
// accepted byte runs through an independent debayer predictor. The expected
// pixels queue up and every output beat is compared field by field.
// ----------------------------------------------------------------------------
module rbds_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [7:0]                    raw_byte_i,
  input  logic                          frame_start_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  input  logic                          last_of_pair_i,
  input  logic                          end_of_row_i,
  input  logic                          cfg_we_i,
  input  logic [rbds_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rbds_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int unsigned                   mismatches_o,
  output int unsigned                   pending_o,
  output int unsigned                   pixels_o
);

  // gamma curve, entry 0 in the top byte
  localparam logic [1023:0] TONE_CURVE = {
    8'd0,   8'd28,  8'd39,  8'd46,  8'd53,  8'd59,  8'd64,  8'd68,
    8'd73,  8'd77,  8'd80,  8'd84,  8'd87,  8'd90,  8'd94,  8'd97,
    8'd99,  8'd102, 8'd105, 8'd108, 8'd110, 8'd113, 8'd115, 8'd117,
    8'd120, 8'd122, 8'd124, 8'd126, 8'd128, 8'd130, 8'd132, 8'd134,
    8'd136, 8'd138, 8'd140, 8'd142, 8'd144, 8'd146, 8'd147, 8'd149,
    8'd151, 8'd153, 8'd154, 8'd156, 8'd158, 8'd159, 8'd161, 8'd162,
    8'd164, 8'd165, 8'd167, 8'd168, 8'd170, 8'd171, 8'd173, 8'd174,
    8'd176, 8'd177, 8'd179, 8'd180, 8'd181, 8'd183, 8'd184, 8'd185,
    8'd187, 8'd188, 8'd189, 8'd191, 8'd192, 8'd193, 8'd195, 8'd196,
    8'd197, 8'd198, 8'd199, 8'd201, 8'd202, 8'd203, 8'd204, 8'd206,
    8'd207, 8'd208, 8'd209, 8'd210, 8'd211, 8'd212, 8'd214, 8'd215,
    8'd216, 8'd217, 8'd218, 8'd219, 8'd220, 8'd221, 8'd222, 8'd223,
    8'd225, 8'd226, 8'd227, 8'd228, 8'd229, 8'd230, 8'd231, 8'd232,
    8'd233, 8'd234, 8'd235, 8'd236, 8'd237, 8'd238, 8'd239, 8'd240,
    8'd241, 8'd242, 8'd243, 8'd244, 8'd245, 8'd246, 8'd247, 8'd248,
    8'd249, 8'd249, 8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd255
  };

  // predictor state
  logic [7:0]                    row_store [rbds_pkg::MaxRowBytes];
  logic [rbds_pkg::CfgDataW-1:0] row_bytes_q;
  logic                          gamma_q;
  logic [31:0]                   odd_group;   // first four bytes of the group, oldest on top
  int unsigned                   col;
  logic [2:0]                    grp;
  logic                          odd;

  rbds_pkg::pix_t                pixel_q [$];
  int unsigned                   n_bad = 0;
  int unsigned                   n_pix = 0;

  function automatic logic [9:0] sample10(input logic [7:0] hi, input logic [7:0] lows,
                                          input logic [1:0] pos);
    return {hi, lows[(3 - pos) * 2 +: 2]};
  endfunction

  function automatic logic [7:0] clip10(input logic [9:0] v);
    return (v > 10'd255) ? 8'hff : v[7:0];
  endfunction

  function automatic logic [7:0] tone(input logic [6:0] i);
    return TONE_CURVE[(127 - i) * 8 +: 8];
  endfunction

  task automatic report_mismatch(input string detail);
    n_bad++;
    $display("MISMATCH at pixel %0d: %s", n_pix, detail);
  endtask

  task automatic debayer_byte(input logic [7:0] b, input logic fs);
    int unsigned    len;
    logic [7:0]     row0 [5];
    logic [7:0]     row1 [5];
    logic [1:0]     ev;
    logic [1:0]     od;
    logic [10:0]    g_sum;
    logic [8:0]     h_sum;
    rbds_pkg::pix_t px;
    len = row_bytes_q;
    if (len < rbds_pkg::MinRowBytes) len = rbds_pkg::MinRowBytes;
    if (len > rbds_pkg::MaxRowBytes) len = rbds_pkg::MaxRowBytes;
    if (fs) begin
      col = 0;
      grp = '0;
      odd = 1'b0;
    end
    if (!odd) begin
      row_store[col] = b;
    end else if (grp == rbds_pkg::GroupLastPos) begin
      for (int k = 0; k < 5; k++) row0[k] = row_store[col - 4 + k];
      row1[0] = odd_group[31:24];
      row1[1] = odd_group[23:16];
      row1[2] = odd_group[15:8];
      row1[3] = odd_group[7:0];
      row1[4] = b;
      for (int k = 0; k < 2; k++) begin
        ev = {k[0], 1'b0};
        od = {k[0], 1'b1};
        if (gamma_q) begin
          px.red   = tone(row1[od][7:1]);
          h_sum    = {1'b0, row0[od]} + {1'b0, row1[ev]};
          px.green = tone(h_sum[8:2]);
          px.blue  = tone(row0[ev][7:1]);
        end else begin
          px.red   = clip10(sample10(row1[od], row1[4], od));
          g_sum    = {1'b0, sample10(row0[od], row0[4], od)}
                   + {1'b0, sample10(row1[ev], row1[4], ev)};
          px.green = clip10(g_sum[10:1]);
          px.blue  = clip10(sample10(row0[ev], row0[4], ev));
        end
        px.last_of_pair = k[0];
        px.end_of_row   = k[0] && (col + 5 >= len);
        pixel_q.push_back(px);
      end
    end
    if (grp < rbds_pkg::GroupLastPos) odd_group = {odd_group[23:0], b};
    if (col + 1 >= len) begin
      col = 0;
      grp = '0;
      odd = ~odd;
    end else begin
      col = col + 1;
      grp = (grp >= rbds_pkg::GroupLastPos) ? 3'd0 : grp + 3'd1;
    end
  endtask

  task automatic check_pixel();
    rbds_pkg::pix_t want;
    if (pixel_q.size() == 0) begin
      report_mismatch($sformatf("unexpected beat r%0d g%0d b%0d", red_i, green_i, blue_i));
    end else begin
      want = pixel_q.pop_front();
      if (red_i !== want.red)
        report_mismatch($sformatf("red %0d, expected %0d", red_i, want.red));
      if (green_i !== want.green)
        report_mismatch($sformatf("green %0d, expected %0d", green_i, want.green));
      if (blue_i !== want.blue)
        report_mismatch($sformatf("blue %0d, expected %0d", blue_i, want.blue));
      if (last_of_pair_i !== want.last_of_pair)
        report_mismatch($sformatf("last_of_pair %0b, expected %0b", last_of_pair_i,
                                  want.last_of_pair));
      if (end_of_row_i !== want.end_of_row)
        report_mismatch($sformatf("end_of_row %0b, expected %0b", end_of_row_i,
                                  want.end_of_row));
    end
    n_pix++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q = rbds_pkg::RowBytesReset;
      gamma_q     = 1'b0;
      odd_group   = '0;
      col         = 0;
      grp         = '0;
      odd         = 1'b0;
      pixel_q.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
      pixels_o     <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_pixel();
      if (cfg_we_i) begin
        if (cfg_idx_i == rbds_pkg::CfgRowBytes) row_bytes_q = cfg_wdata_i;
        else if (cfg_idx_i == rbds_pkg::CfgGamma) gamma_q = cfg_wdata_i[0];
      end
      if (in_valid_i && in_ready_i) debayer_byte(raw_byte_i, frame_start_i);
      mismatches_o <= n_bad;
      pending_o    <= pixel_q.size();
      pixels_o     <= n_pix;
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the RAW10 BGGR downsampler. Streams framed rows
// of packed bytes under changing row lengths and tone modes, with random
// gaps on the input and back-pressure on the output; rbds_checker predicts
// and compares every pixel.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned RandomBeats = 1560;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned RbW         = rbds_pkg::CfgDataW;

  // directed rows, first byte in the top bits: full scale, then clip edges
  localparam logic [159:0] LinearRows = {40'hff_ff_ff_ff_ff, 40'hff_ff_ff_ff_ff,
                                         40'h00_00_3f_40_ff, 40'h3f_40_00_00_00};
  localparam logic [79:0]  GammaRows  = {40'hff_ff_01_01_00, 40'hff_ff_00_00_ff};

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_ready_o;
  logic [7:0]                    raw_byte_i    = '0;
  logic                          frame_start_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i   = 1'b0;
  logic [7:0]                    red_o;
  logic [7:0]                    green_o;
  logic [7:0]                    blue_o;
  logic                          last_of_pair_o;
  logic                          end_of_row_o;
  logic                          cfg_we_i      = 1'b0;
  logic [rbds_pkg::CfgIdxW-1:0]  cfg_idx_i     = rbds_pkg::CfgRowBytes;
  logic [rbds_pkg::CfgDataW-1:0] cfg_wdata_i   = '0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned pixels;
  int unsigned src_gap_pct    = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned beats_sent     = 0;
  int unsigned settings       = 0;

  raw10_bayer_downsample_rgb u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .raw_byte_i     (raw_byte_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .last_of_pair_o (last_of_pair_o),
    .end_of_row_o   (end_of_row_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  rbds_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .raw_byte_i     (raw_byte_i),
    .frame_start_i  (frame_start_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_i          (red_o),
    .green_i        (green_o),
    .blue_i         (blue_o),
    .last_of_pair_i (last_of_pair_o),
    .end_of_row_i   (end_of_row_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .pixels_o       (pixels)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99, 0) >= sink_stall_pct);
  end

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_gap_pct = 48; sink_stall_pct = 0;  end
      2: begin src_gap_pct = 0;  sink_stall_pct = 48; end
      default: begin src_gap_pct = 18; sink_stall_pct = 18; end
    endcase
  endtask

  // valid is only lowered for a gap, so back-to-back beats keep it high
  task automatic push_byte(input logic [7:0] b, input logic fs);
    if ($urandom_range(99, 0) < src_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < src_gap_pct);
    end
    in_valid_i    <= 1'b1;
    raw_byte_i    <= b;
    frame_start_i <= fs;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  // random bytes; noise throws in the odd stray frame start
  task automatic send_bytes(input int unsigned n, input logic lead_fs, input logic noise);
    logic [7:0] b;
    logic       fs;
    for (int unsigned i = 0; i < n; i++) begin
      b  = 8'($urandom_range(255, 0));
      fs = (i == 0 && lead_fs) || (noise && $urandom_range(199, 0) == 0);
      push_byte(b, fs);
    end
  endtask

  // let every expected pixel out, then cover bytes still in the pipe
  task automatic drain();
    int unsigned spins;
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    spins = 0;
    while (pending != 0 && spins < DrainLimit) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [rbds_pkg::CfgDataW-1:0] rb, input logic gamma);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= rbds_pkg::CfgRowBytes;
    cfg_wdata_i <= rb;
    @(posedge clk_i);
    cfg_idx_i   <= rbds_pkg::CfgGamma;
    cfg_wdata_i <= {{(rbds_pkg::CfgDataW-1){1'b0}}, gamma};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings++;
  endtask

  initial begin
    int unsigned                   phase;
    int unsigned                   first_beat;
    int unsigned                   len;
    int unsigned                   pick;
    logic [rbds_pkg::CfgDataW-1:0] rb;
    logic                          g;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0);
    write_cfg(11'd5, 1'b0);
    for (int unsigned i = 0; i < 20; i++) push_byte(LinearRows[159 - 8 * i -: 8], i == 0);

    // row length below the minimum, gamma on
    drain();
    write_cfg(11'd3, 1'b1);
    for (int unsigned i = 0; i < 10; i++) push_byte(GammaRows[79 - 8 * i -: 8], i == 0);

    phase      = 0;
    first_beat = beats_sent;
    while (beats_sent - first_beat < RandomBeats) begin
      set_idling(phase % 4);
      g = 1'($urandom_range(1, 0));
      drain();
      if (phase % 5 == 4) begin
        // stop halfway through an odd row, then cut the row length under it
        rb = RbW'(5 * $urandom_range(12, 4));
        len = rb;
        write_cfg(rb, g);
        send_bytes(len + len / 2, 1'b1, 1'b0);
        drain();
        rb = RbW'($urandom_range(len / 2 - 1, 5));
        write_cfg(rb, g);
        send_bytes(4 * rb, 1'b0, 1'b1);
      end else begin
        pick = $urandom_range(9, 0);
        if (pick == 0) rb = RbW'($urandom_range(4, 0));
        else if (pick < 3) rb = RbW'($urandom_range(63, 6));
        else rb = RbW'(5 * $urandom_range(12, 1));
        len = (rb < rbds_pkg::MinRowBytes) ? rbds_pkg::MinRowBytes : rb;
        write_cfg(rb, g);
        send_bytes(len * $urandom_range(6, 2), 1'b1, 1'b1);
      end
      phase++;
    end

    drain();

    $display("%0d bytes streamed under %0d register settings, rows of 5 to 63 bytes",
             beats_sent, settings);
    $display("%0d pixels compared, linear and gamma, %0d mismatches, %0d never arrived",
             pixels, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("run timed out");
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/rbds_pkg.sv
hdl/rbds_ram.sv
hdl/rbds_front.sv
hdl/rbds_colour.sv
hdl/rbds_fifo.sv
hdl/raw10_bayer_downsample_rgb.sv
verif/rbds_checker.sv
verif/tb_top.sv
